// ----- rtl/tld_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_pkg
// Shared types, sizes and codes of the task lease dispatcher.
// ----------------------------------------------------------------------------
package tld_pkg;

    localparam int MAX_TASKS   = 64;
    localparam int TASK_IDX_W  = $clog2(MAX_TASKS);
    localparam int CNT_W       = TASK_IDX_W + 1;
    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int CFG_W       = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int IDX_FIELD_W = 7;
    localparam int LEASE_W     = ID_W + TIME_W;
    localparam int LEASE_DEPTH = 2 * MAX_TASKS;
    localparam int LEASE_AW    = TASK_IDX_W + 1;

    localparam logic [CNT_W-1:0]  MAP_COUNT_RST     = CNT_W'(1);
    localparam logic [CNT_W-1:0]  REDUCE_COUNT_RST  = CNT_W'(1);
    localparam logic [TIME_W-1:0] LEASE_TIMEOUT_RST = TIME_W'(1000);

    localparam logic signed [IDX_FIELD_W-1:0] SUM_FAIL_IDX = -IDX_FIELD_W'(1);

    localparam logic [CFG_IDX_W-1:0] CFG_MAP_COUNT     = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_REDUCE_COUNT  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_LEASE_TIMEOUT = CFG_IDX_W'(2);

    typedef enum logic [1:0] {
        MODE_ASK    = 2'd0,
        MODE_SUBMIT = 2'd1,
        MODE_TICK   = 2'd2,
        MODE_RSVD   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_MAP    = 2'd1,
        KIND_REDUCE = 2'd2,
        KIND_SUM    = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LEASE_CHK,
        S_GRANT,
        S_SUM,
        S_SUB_CHK,
        S_DONE_SCAN,
        S_RESP
    } t_state;

    // Task counts are used clamped to 1..MAX_TASKS.
    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        begin
            if (c == '0) begin
                r = CNT_W'(1);
            end else if (c > CNT_W'(MAX_TASKS)) begin
                r = CNT_W'(MAX_TASKS);
            end else begin
                r = c;
            end
            return r;
        end
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tld_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tld_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
module tld_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/task_lease_dispatcher.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// task_lease_dispatcher
// Map, reduce and sum task dispatcher with timed leases.
// ----------------------------------------------------------------------------
// One transaction is handled at a time; the input is stalled from acceptance
// until the result is loaded into the output register, which may still hold
// the previous result while the next transaction is accepted. A tick, a
// reserved mode, a sum submit, a submit of type none, a map or reduce submit
// whose index is out of range and an ask on a finished job go straight to the
// response step, and a sum ask passes through the sum step first. A map or
// reduce ask walks the task entries of the open phase in order: a done entry
// is skipped, a leased entry needs a lease check step because its owner and
// start time come from the lease RAM with a registered read, and granting a
// free entry adds a grant step. A map or reduce submit in range reads the
// lease RAM first; a refused one then responds, and an accepted one then
// sweeps the done bits one per cycle. While the receiver holds off the
// previous result, the response step waits. A single expiry comparator (time
// subtract and compare with the timeout) is shared by all entries and by the
// sum lease.
module task_lease_dispatcher (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_we,
    input  wire logic [tld_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [tld_pkg::CFG_W-1:0]              i_cfg_data,
    input  wire logic                                   i_in_valid,
    output logic                                        o_in_stall,
    input  wire logic [1:0]                             i_mode,
    input  wire logic [tld_pkg::ID_W-1:0]               i_worker_id,
    input  wire logic [1:0]                             i_task_type,
    input  wire logic signed [tld_pkg::IDX_FIELD_W-1:0] i_task_index,
    output logic                                        o_out_valid,
    input  wire logic                                   i_out_stall,
    output logic [1:0]                                  o_task_kind,
    output logic [tld_pkg::CNT_W-1:0]                   o_grant_index,
    output logic                                        o_job_finished
);

    localparam int IW = tld_pkg::TASK_IDX_W;

    tld_pkg::t_state r_state, n_state;

    logic [tld_pkg::CNT_W-1:0]     r_map_count, r_red_count;
    logic [tld_pkg::TIME_W-1:0]    r_timeout;
    logic [tld_pkg::MAX_TASKS-1:0] r_map_done, n_map_done, r_map_valid, n_map_valid;
    logic [tld_pkg::MAX_TASKS-1:0] r_red_done, n_red_done, r_red_valid, n_red_valid;
    logic                          r_sum_valid, n_sum_valid;
    logic [tld_pkg::ID_W-1:0]      r_sum_owner, n_sum_owner;
    logic [tld_pkg::TIME_W-1:0]    r_sum_start, n_sum_start;
    logic                          r_map_ph_done, n_map_ph_done;
    logic                          r_red_ph_done, n_red_ph_done;
    logic                          r_finished, n_finished;
    logic [tld_pkg::TIME_W-1:0]    r_time, n_time;
    logic [tld_pkg::CNT_W-1:0]     r_idx, n_idx;
    logic                          r_phase, n_phase;
    logic [tld_pkg::ID_W-1:0]      r_req_id, n_req_id;
    tld_pkg::t_kind                r_grant_kind, n_grant_kind;
    logic [tld_pkg::CNT_W-1:0]     r_grant_idx, n_grant_idx;
    logic                          r_out_valid, n_out_valid;
    tld_pkg::t_kind                r_out_kind, n_out_kind;
    logic [tld_pkg::CNT_W-1:0]     r_out_idx, n_out_idx;
    logic                          r_out_fin, n_out_fin;

    logic                          in_acc;
    logic [tld_pkg::CNT_W-1:0]     map_eff, red_eff, cur_cnt;
    logic [IW-1:0]                 cur_pos;
    logic                          cur_done, cur_valid;
    logic                          ram_we, ram_re;
    logic [tld_pkg::LEASE_AW-1:0]  ram_waddr, ram_raddr;
    logic [tld_pkg::LEASE_W-1:0]   ram_wdata, ram_rdata;
    logic [tld_pkg::ID_W-1:0]      rd_owner;
    logic [tld_pkg::TIME_W-1:0]    rd_start, exp_start, age;
    logic                          expired;
    tld_pkg::t_mode                req_mode;
    tld_pkg::t_kind                req_type;

    assign in_acc    = i_in_valid && !o_in_stall;
    assign map_eff   = tld_pkg::eff_count(r_map_count);
    assign red_eff   = tld_pkg::eff_count(r_red_count);
    assign cur_cnt   = r_phase ? red_eff : map_eff;
    assign cur_pos   = r_idx[IW-1:0];
    assign cur_done  = r_phase ? r_red_done[cur_pos] : r_map_done[cur_pos];
    assign cur_valid = r_phase ? r_red_valid[cur_pos] : r_map_valid[cur_pos];
    assign rd_owner  = ram_rdata[tld_pkg::LEASE_W-1 -: tld_pkg::ID_W];
    assign rd_start  = ram_rdata[tld_pkg::TIME_W-1:0];
    assign req_mode  = tld_pkg::t_mode'(i_mode);
    assign req_type  = tld_pkg::t_kind'(i_task_type);

    // Shared expiry comparator: the age wraps with the time counter.
    assign exp_start = (r_state == tld_pkg::S_SUM) ? r_sum_start : rd_start;
    assign age       = r_time - exp_start;
    assign expired   = age > r_timeout;

    tld_ram #(
        .WIDTH (tld_pkg::LEASE_W),
        .DEPTH (tld_pkg::LEASE_DEPTH)
    ) u_lease_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state       = r_state;
        n_map_done    = r_map_done;
        n_map_valid   = r_map_valid;
        n_red_done    = r_red_done;
        n_red_valid   = r_red_valid;
        n_sum_valid   = r_sum_valid;
        n_sum_owner   = r_sum_owner;
        n_sum_start   = r_sum_start;
        n_map_ph_done = r_map_ph_done;
        n_red_ph_done = r_red_ph_done;
        n_finished    = r_finished;
        n_time        = r_time;
        n_idx         = r_idx;
        n_phase       = r_phase;
        n_req_id      = r_req_id;
        n_grant_kind  = r_grant_kind;
        n_grant_idx   = r_grant_idx;
        n_out_valid   = r_out_valid && i_out_stall;
        n_out_kind    = r_out_kind;
        n_out_idx     = r_out_idx;
        n_out_fin     = r_out_fin;
        o_in_stall    = (r_state != tld_pkg::S_IDLE);
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_waddr     = {r_phase, cur_pos};
        ram_wdata     = {r_req_id, r_time};
        ram_raddr     = {r_phase, cur_pos};

        unique case (r_state)
            tld_pkg::S_IDLE: begin
                ram_raddr = {req_type == tld_pkg::KIND_REDUCE, i_task_index[IW-1:0]};
                ram_re    = in_acc;
                if (in_acc) begin
                    n_req_id     = i_worker_id;
                    n_grant_kind = tld_pkg::KIND_NONE;
                    n_grant_idx  = '0;
                    n_idx        = '0;
                    n_state      = tld_pkg::S_RESP;
                    unique case (req_mode)
                        tld_pkg::MODE_ASK: begin
                            if (r_finished) begin
                                n_state = tld_pkg::S_RESP;
                            end else if (!r_map_ph_done) begin
                                n_phase = 1'b0;
                                n_state = tld_pkg::S_SCAN;
                            end else if (!r_red_ph_done) begin
                                n_phase = 1'b1;
                                n_state = tld_pkg::S_SCAN;
                            end else begin
                                n_state = tld_pkg::S_SUM;
                            end
                        end
                        tld_pkg::MODE_SUBMIT: begin
                            n_idx = {1'b0, i_task_index[IW-1:0]};
                            if (req_type == tld_pkg::KIND_MAP) begin
                                n_phase = 1'b0;
                                if (!i_task_index[tld_pkg::IDX_FIELD_W-1] &&
                                    $unsigned(i_task_index) < map_eff) begin
                                    n_state = tld_pkg::S_SUB_CHK;
                                end
                            end else if (req_type == tld_pkg::KIND_REDUCE) begin
                                n_phase = 1'b1;
                                if (!i_task_index[tld_pkg::IDX_FIELD_W-1] &&
                                    $unsigned(i_task_index) < red_eff) begin
                                    n_state = tld_pkg::S_SUB_CHK;
                                end
                            end else if (req_type == tld_pkg::KIND_SUM) begin
                                if (i_task_index != tld_pkg::SUM_FAIL_IDX && r_sum_valid &&
                                    r_sum_owner == i_worker_id) begin
                                    n_finished = 1'b1;
                                end
                            end
                        end
                        tld_pkg::MODE_TICK: begin
                            n_time = r_time + 1'b1;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            tld_pkg::S_SCAN: begin
                if (r_idx >= cur_cnt) begin
                    n_state = tld_pkg::S_RESP;
                end else if (cur_done) begin
                    n_idx = r_idx + 1'b1;
                end else if (!cur_valid) begin
                    n_state = tld_pkg::S_GRANT;
                end else begin
                    ram_re  = 1'b1;
                    n_state = tld_pkg::S_LEASE_CHK;
                end
            end
            tld_pkg::S_LEASE_CHK: begin
                if (expired) begin
                    n_state = tld_pkg::S_GRANT;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = tld_pkg::S_SCAN;
                end
            end
            tld_pkg::S_GRANT: begin
                ram_we      = 1'b1;
                n_grant_idx = r_idx;
                if (r_phase) begin
                    n_red_valid[cur_pos] = 1'b1;
                    n_grant_kind         = tld_pkg::KIND_REDUCE;
                end else begin
                    n_map_valid[cur_pos] = 1'b1;
                    n_grant_kind         = tld_pkg::KIND_MAP;
                end
                n_state = tld_pkg::S_RESP;
            end
            tld_pkg::S_SUM: begin
                if (!r_sum_valid || expired) begin
                    n_sum_valid  = 1'b1;
                    n_sum_owner  = r_req_id;
                    n_sum_start  = r_time;
                    n_grant_kind = tld_pkg::KIND_SUM;
                    n_grant_idx  = red_eff;
                end
                n_state = tld_pkg::S_RESP;
            end
            tld_pkg::S_SUB_CHK: begin
                if (cur_valid && rd_owner == r_req_id) begin
                    if (r_phase) begin
                        n_red_done[cur_pos] = 1'b1;
                    end else begin
                        n_map_done[cur_pos] = 1'b1;
                    end
                    n_idx   = '0;
                    n_state = tld_pkg::S_DONE_SCAN;
                end else begin
                    n_state = tld_pkg::S_RESP;
                end
            end
            tld_pkg::S_DONE_SCAN: begin
                // Walk the done bits; reaching the count means the phase closed.
                if (r_idx >= cur_cnt) begin
                    if (r_phase) begin
                        n_red_ph_done = 1'b1;
                    end else begin
                        n_map_ph_done = 1'b1;
                    end
                    n_state = tld_pkg::S_RESP;
                end else if (!cur_done) begin
                    n_state = tld_pkg::S_RESP;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            tld_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_kind  = r_grant_kind;
                    n_out_idx   = r_grant_idx;
                    n_out_fin   = r_finished;
                    n_state     = tld_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = tld_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= tld_pkg::S_IDLE;
            r_map_count   <= tld_pkg::MAP_COUNT_RST;
            r_red_count   <= tld_pkg::REDUCE_COUNT_RST;
            r_timeout     <= tld_pkg::LEASE_TIMEOUT_RST;
            r_map_done    <= '0;
            r_map_valid   <= '0;
            r_red_done    <= '0;
            r_red_valid   <= '0;
            r_sum_valid   <= 1'b0;
            r_map_ph_done <= 1'b0;
            r_red_ph_done <= 1'b0;
            r_finished    <= 1'b0;
            r_time        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_map_done    <= n_map_done;
            r_map_valid   <= n_map_valid;
            r_red_done    <= n_red_done;
            r_red_valid   <= n_red_valid;
            r_sum_valid   <= n_sum_valid;
            r_map_ph_done <= n_map_ph_done;
            r_red_ph_done <= n_red_ph_done;
            r_finished    <= n_finished;
            r_time        <= n_time;
            r_out_valid   <= n_out_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    tld_pkg::CFG_MAP_COUNT:     r_map_count <= i_cfg_data[tld_pkg::CNT_W-1:0];
                    tld_pkg::CFG_REDUCE_COUNT:  r_red_count <= i_cfg_data[tld_pkg::CNT_W-1:0];
                    tld_pkg::CFG_LEASE_TIMEOUT: r_timeout   <= i_cfg_data[tld_pkg::TIME_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum_owner  <= n_sum_owner;
        r_sum_start  <= n_sum_start;
        r_idx        <= n_idx;
        r_phase      <= n_phase;
        r_req_id     <= n_req_id;
        r_grant_kind <= n_grant_kind;
        r_grant_idx  <= n_grant_idx;
        r_out_kind   <= n_out_kind;
        r_out_idx    <= n_out_idx;
        r_out_fin    <= n_out_fin;
    end

    assign o_out_valid    = r_out_valid;
    assign o_task_kind    = r_out_kind;
    assign o_grant_index  = r_out_idx;
    assign o_job_finished = r_out_fin;

    // Once finished, the job stays finished until reset.
    a_finish_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |=> r_finished)
        else $error("job finished flag dropped");

    // Phases open strictly in order.
    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_red_ph_done |-> r_map_ph_done)
        else $error("reduce phase closed before map phase");

    // The job can finish only through the holder of a sum lease.
    a_finish_needs_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_finished |-> (r_red_ph_done && r_sum_valid))
        else $error("job finished without a sum lease");

    // A new result is only loaded at the end of a transaction.
    a_out_from_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && r_state != tld_pkg::S_RESP) |=> !r_out_valid)
        else $error("result produced outside the response step");

    // A map grant leaves the granted entry leased.
    a_grant_leased: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == tld_pkg::S_GRANT && !r_phase) |=> r_map_valid[$past(cur_pos)])
        else $error("granted map task has no lease");

endmodule
`default_nettype wire
